// ===== rtl/bitmap_find_next_bit_engine_unit_defines.svh =====
// Assertion macros used by the bitmap find-next-bit engine controller.
`ifndef BITMAP_FIND_NEXT_BIT_ENGINE_UNIT_DEFINES_SVH
`define BITMAP_FIND_NEXT_BIT_ENGINE_UNIT_DEFINES_SVH

// Same-cycle implication, clocked on clk, disabled while arst_n is low.
`define BFNB_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, clocked on clk, disabled while arst_n is low.
`define BFNB_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

// ===== rtl/bfnb_pkg.sv =====
// Package: sizes, mode codes, control structs and lowest-set-bit function.
`timescale 1ns / 1ps
`default_nettype none
package bfnb_pkg;

	localparam int WORD_BITS  = 32;
	localparam int WORDS      = 32;
	localparam int TOTAL_BITS = WORD_BITS * WORDS;
	localparam int MODE_W     = 3;
	localparam int IDX_W      = 10;
	localparam int LIM_W      = 11;
	localparam int WPTR_W     = $clog2(WORDS);
	localparam int BPOS_W     = $clog2(WORD_BITS);
	localparam int PAD_W      = LIM_W - WPTR_W - BPOS_W;

	localparam logic [MODE_W-1:0] MODE_TEST       = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TEST_SET   = 3'd1;
	localparam logic [MODE_W-1:0] MODE_TEST_CLEAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_FIND_SET   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FIND_ZERO  = 3'd4;

	localparam logic [LIM_W-1:0] TOTAL_LIM = LIM_W'(TOTAL_BITS);

	typedef struct packed {
		logic load_req;
		logic step;
		logic load_rsp;
	} bfnb_cmd_t;

	typedef struct packed {
		logic done;
	} bfnb_sts_t;

	// Lowest set bit of a nonzero word by binary halving.
	function automatic logic [BPOS_W-1:0] lowest_set(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] t;
		logic [BPOS_W-1:0]    n;
		t = w;
		n = '0;
		if ((t & 32'hffff) == '0) begin
			n = n + BPOS_W'(16);
			t = t >> 16;
		end
		if ((t & 32'hff) == '0) begin
			n = n + BPOS_W'(8);
			t = t >> 8;
		end
		if ((t & 32'hf) == '0) begin
			n = n + BPOS_W'(4);
			t = t >> 4;
		end
		if ((t & 32'h3) == '0) begin
			n = n + BPOS_W'(2);
			t = t >> 2;
		end
		if ((t & 32'h1) == '0) begin
			n = n + BPOS_W'(1);
		end
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/bfnb_req_if.sv =====
// Request channel: operation, bit index and search limit.
`timescale 1ns / 1ps
`default_nettype none
interface bfnb_req_if;
	logic                           valid;
	logic                           ready;
	logic [bfnb_pkg::MODE_W-1:0]    mode;
	logic [bfnb_pkg::IDX_W-1:0]     bit_index;
	logic [bfnb_pkg::LIM_W-1:0]     search_limit;

	modport source (output valid, output mode, output bit_index, output search_limit,
		input ready);
	modport sink (input valid, input mode, input bit_index, input search_limit,
		output ready);
endinterface
`default_nettype wire

// ===== rtl/bfnb_rsp_if.sv =====
// Response channel: old bit value and found index.
`timescale 1ns / 1ps
`default_nettype none
interface bfnb_rsp_if;
	logic                           valid;
	logic                           ready;
	logic                           old_bit;
	logic [bfnb_pkg::LIM_W-1:0]     found_index;

	modport source (output valid, output old_bit, output found_index, input ready);
	modport sink (input valid, input old_bit, input found_index, output ready);
endinterface
`default_nettype wire

// ===== rtl/bitmap_find_next_bit_engine_unit.sv =====
// Tests need no scan; finds scan one word a cycle until a hit or the limit.
// A new request is taken only while idle, after the last one has loaded its result; a finished
// request waits while the response register is still full.
// The word scan loop in the datapath sets how long a find runs; the response register lets the next
// request be taken while a result still waits.
// Reset: arst_n clears the bitmap to all zeros, the controller to idle and response valid.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_find_next_bit_engine_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	bfnb_req_if.sink   req,
	bfnb_rsp_if.source rsp
);

	bfnb_pkg::bfnb_cmd_t cmd;
	bfnb_pkg::bfnb_sts_t sts;

	bfnb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	bfnb_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.mode         (req.mode),
		.bit_index    (req.bit_index),
		.search_limit (req.search_limit),
		.old_bit      (rsp.old_bit),
		.found_index  (rsp.found_index)
	);

endmodule
`default_nettype wire

// ===== rtl/bfnb_datapath.sv =====
// Datapath: bitmap storage, request registers, word scan and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bfnb_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire bfnb_pkg::bfnb_cmd_t            cmd,
	output bfnb_pkg::bfnb_sts_t                 sts,
	input  wire logic [bfnb_pkg::MODE_W-1:0]    mode,
	input  wire logic [bfnb_pkg::IDX_W-1:0]     bit_index,
	input  wire logic [bfnb_pkg::LIM_W-1:0]     search_limit,
	output logic                                old_bit,
	output logic [bfnb_pkg::LIM_W-1:0]          found_index
);

	logic [bfnb_pkg::WORD_BITS-1:0] bitmap_q [bfnb_pkg::WORDS];

	logic [bfnb_pkg::MODE_W-1:0] mode_q;
	logic [bfnb_pkg::IDX_W-1:0]  start_q;
	logic [bfnb_pkg::LIM_W-1:0]  size_q;
	logic [bfnb_pkg::WPTR_W-1:0] ptr_q;
	logic                        first_q;

	logic [bfnb_pkg::WORD_BITS-1:0] word;
	logic [bfnb_pkg::WORD_BITS-1:0] tmp;
	logic [bfnb_pkg::BPOS_W-1:0]    bpos;
	logic [bfnb_pkg::WPTR_W:0]      nptr;
	logic [bfnb_pkg::LIM_W-1:0]     next_base;
	logic [bfnb_pkg::LIM_W-1:0]     hit_idx;
	logic                           is_test;
	logic                           is_find;
	logic                           early;
	logic                           r_old;
	logic [bfnb_pkg::LIM_W-1:0]     r_found;

	assign word      = bitmap_q[ptr_q];
	assign bpos      = start_q[bfnb_pkg::BPOS_W-1:0];
	assign is_test   = (mode_q == bfnb_pkg::MODE_TEST) || (mode_q == bfnb_pkg::MODE_TEST_SET)
		|| (mode_q == bfnb_pkg::MODE_TEST_CLEAR);
	assign is_find   = (mode_q == bfnb_pkg::MODE_FIND_SET)
		|| (mode_q == bfnb_pkg::MODE_FIND_ZERO);
	assign early     = (size_q == '0) || ({1'b0, start_q} >= size_q);
	assign nptr      = {1'b0, ptr_q} + (bfnb_pkg::WPTR_W+1)'(1);
	assign next_base = bfnb_pkg::LIM_W'({nptr, {bfnb_pkg::BPOS_W{1'b0}}});
	assign hit_idx   = {{bfnb_pkg::PAD_W{1'b0}}, ptr_q, bfnb_pkg::lowest_set(tmp)};

	always_comb begin
		tmp = (mode_q == bfnb_pkg::MODE_FIND_ZERO) ? ~word : word;
		if (first_q) begin
			tmp = tmp & ({bfnb_pkg::WORD_BITS{1'b1}} << bpos);
		end
	end

	always_comb begin
		r_old    = 1'b0;
		r_found  = '0;
		sts.done = 1'b1;
		if (is_test) begin
			r_old = word[bpos];
		end else if (is_find) begin
			if (early) begin
				r_found = size_q;
			end else if (tmp != '0) begin
				r_found = (hit_idx < size_q) ? hit_idx : size_q;
			end else if (next_base >= size_q) begin
				r_found = size_q;
			end else begin
				sts.done = 1'b0;
			end
		end
	end

	// Latch the request, saturating the limit at the bitmap size; advance the word pointer on a step.
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			mode_q  <= mode;
			start_q <= bit_index;
			size_q  <= (search_limit > bfnb_pkg::TOTAL_LIM) ? bfnb_pkg::TOTAL_LIM : search_limit;
			ptr_q   <= bit_index[bfnb_pkg::IDX_W-1:bfnb_pkg::BPOS_W];
			first_q <= 1'b1;
		end else if (cmd.step) begin
			ptr_q   <= nptr[bfnb_pkg::WPTR_W-1:0];
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bfnb_pkg::WORDS; i++) begin
				bitmap_q[i] <= '0;
			end
		end else if (cmd.load_rsp) begin
			if (mode_q == bfnb_pkg::MODE_TEST_SET) begin
				bitmap_q[ptr_q][bpos] <= 1'b1;
			end else if (mode_q == bfnb_pkg::MODE_TEST_CLEAR) begin
				bitmap_q[ptr_q][bpos] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_rsp) begin
			old_bit     <= r_old;
			found_index <= r_found;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/bfnb_ctrl.sv =====
// Controller: request acceptance, scan sequencing and response valid.
`timescale 1ns / 1ps
`default_nettype none
`include "bitmap_find_next_bit_engine_unit_defines.svh"
module bfnb_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_ready,
	output logic                       rsp_valid,
	input  wire logic                  rsp_ready,
	output bfnb_pkg::bfnb_cmd_t        cmd,
	input  wire bfnb_pkg::bfnb_sts_t   sts
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_BUSY = 1'b1;

	logic state_q;
	logic state_d;
	logic rsp_valid_q;
	logic rsp_free;

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp_free  = !rsp_valid_q || rsp_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_BUSY;
				end
			end
			ST_BUSY: begin
				if (sts.done) begin
					// hold the finished request until the output register frees
					if (rsp_free) begin
						cmd.load_rsp = 1'b1;
						state_d      = ST_IDLE;
					end
				end else begin
					cmd.step = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= cmd.load_rsp || (rsp_valid_q && !rsp_ready);
		end
	end

	`BFNB_ASSERT_NOW(a_rsp_only_busy, cmd.load_rsp, state_q == ST_BUSY, "response load outside busy")
	`BFNB_ASSERT_NOW(a_no_overwrite, cmd.load_rsp, !rsp_valid_q || rsp_ready, "pending response overwritten")
	`BFNB_ASSERT_NOW(a_step_excl, cmd.step, state_q == ST_BUSY && !cmd.load_rsp, "step clashes with finish")
	`BFNB_ASSERT_NEXT(a_accept_busy, req_valid && req_ready, state_q == ST_BUSY, "accepted request not started")

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Testbench for the bitmap find-next-bit engine: directed and random requests against a shadow bitmap.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import bfnb_pkg::*;

	localparam logic [MODE_W-1:0] MODE_TOP = 3'd7;
	localparam int CLK_HALF = 4;

	typedef struct packed {
		logic             old_bit;
		logic [LIM_W-1:0] found_index;
	} bit_result_t;

	logic clk;
	logic arst_n;

	bfnb_req_if req_ch ();
	bfnb_rsp_if rsp_ch ();

	bitmap_find_next_bit_engine_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [WORD_BITS-1:0] shadow_map [WORDS];
	bit_result_t          pending_results [$];
	int                   err_count = 0;
	bit                   gaps_on = 1'b0;
	bit                   stalls_on = 1'b0;
	int                   burst_left = 0;
	int                   holdoff_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	initial begin : limit_guard
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

	// Lowest bit at or after start that matches, clipped to the saturated limit.
	function automatic logic [LIM_W-1:0] scan_bitmap(input logic [IDX_W-1:0] start,
		input logic [LIM_W-1:0] lim, input bit want_zero);
		int                   size;
		int                   base;
		int                   b;
		logic [WORD_BITS-1:0] w;
		size = (int'(lim) > TOTAL_BITS) ? TOTAL_BITS : int'(lim);
		if (size == 0 || int'(start) >= size)
			return LIM_W'(size);
		base = (int'(start) / WORD_BITS) * WORD_BITS;
		w = shadow_map[base / WORD_BITS] ^ {WORD_BITS{want_zero}};
		w &= {WORD_BITS{1'b1}} << (int'(start) % WORD_BITS);
		while (w == '0) begin
			base += WORD_BITS;
			if (base >= size)
				return LIM_W'(size);
			w = shadow_map[base / WORD_BITS] ^ {WORD_BITS{want_zero}};
		end
		b = 0;
		while (!w[b])
			b++;
		base += b;
		return LIM_W'((base < size) ? base : size);
	endfunction

	function automatic bit_result_t apply_request(input logic [MODE_W-1:0] mode,
		input logic [IDX_W-1:0] idx, input logic [LIM_W-1:0] lim);
		bit_result_t r;
		int          pos;
		r = '0;
		pos = int'(idx) % TOTAL_BITS;
		case (mode)
		MODE_TEST, MODE_TEST_SET, MODE_TEST_CLEAR: begin
			r.old_bit = shadow_map[pos / WORD_BITS][pos % WORD_BITS];
			if (mode == MODE_TEST_SET)
				shadow_map[pos / WORD_BITS][pos % WORD_BITS] = 1'b1;
			else if (mode == MODE_TEST_CLEAR)
				shadow_map[pos / WORD_BITS][pos % WORD_BITS] = 1'b0;
		end
		MODE_FIND_SET: begin
			r.found_index = scan_bitmap(idx, lim, 1'b0);
		end
		MODE_FIND_ZERO: begin
			r.found_index = scan_bitmap(idx, lim, 1'b1);
		end
		default: begin
		end
		endcase
		return r;
	endfunction

	task automatic send_request(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
		input logic [LIM_W-1:0] lim);
		int gap;
		@(negedge clk);
		req_ch.valid        <= 1'b1;
		req_ch.mode         <= mode;
		req_ch.bit_index    <= idx;
		req_ch.search_limit <= lim;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(apply_request(mode, idx, lim));
		if (gaps_on) begin
			if (burst_left == 0) begin
				gap = $urandom_range(1, 8);
				repeat (gap) begin
					@(negedge clk);
					req_ch.valid <= 1'b0;
				end
				burst_left = $urandom_range(1, 12);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Random request, half of the indices clustered in three words from hot_word.
	task automatic send_random(input int hot_word);
		int                sel;
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  idx;
		logic [LIM_W-1:0]  lim;
		sel = $urandom_range(0, 99);
		if (sel < 35)
			mode = MODE_TEST_SET;
		else if (sel < 50)
			mode = MODE_TEST_CLEAR;
		else if (sel < 60)
			mode = MODE_TEST;
		else if (sel < 78)
			mode = MODE_FIND_SET;
		else if (sel < 95)
			mode = MODE_FIND_ZERO;
		else
			mode = MODE_W'($urandom_range(int'(MODE_FIND_ZERO) + 1, int'(MODE_TOP)));
		if ($urandom_range(0, 1))
			idx = IDX_W'($urandom_range(0, TOTAL_BITS - 1));
		else
			idx = IDX_W'(hot_word * WORD_BITS + $urandom_range(0, 3 * WORD_BITS - 1));
		sel = $urandom_range(0, 9);
		if (sel < 4)
			lim = TOTAL_LIM;
		else if (sel < 6)
			lim = LIM_W'($urandom_range(0, 2 ** LIM_W - 1));
		else if (sel < 8)
			lim = LIM_W'($urandom_range(0, TOTAL_BITS));
		else
			lim = LIM_W'(int'(idx) + $urandom_range(0, 64));
		send_request(mode, idx, lim);
	endtask

	task automatic test_reset_state();
		send_request(MODE_FIND_SET, 0, TOTAL_LIM);
		send_request(MODE_FIND_ZERO, 0, TOTAL_LIM);
		send_request(MODE_TEST, IDX_W'(TOTAL_BITS - 1), 0);
	endtask

	task automatic test_bit_updates();
		send_request(MODE_TEST_SET, 0, 0);
		send_request(MODE_TEST_SET, 0, 0);
		send_request(MODE_TEST_SET, IDX_W'(TOTAL_BITS - 1), TOTAL_LIM);
		send_request(MODE_TEST_CLEAR, IDX_W'(TOTAL_BITS - 1), 0);
		send_request(MODE_TEST_CLEAR, IDX_W'(TOTAL_BITS - 1), 0);
		send_request(MODE_TEST_SET, 31, 0);
		send_request(MODE_TEST_SET, 32, 0);
		send_request(MODE_TEST, 31, LIM_W'(2 ** LIM_W - 1));
	endtask

	// Bits 0, 31 and 32 are set at this point.
	task automatic test_search_edges();
		logic [MODE_W-1:0] m;
		send_request(MODE_FIND_SET, 1, LIM_W'(2 ** LIM_W - 1));
		send_request(MODE_FIND_SET, 0, 0);
		send_request(MODE_FIND_ZERO, 5, 5);
		send_request(MODE_FIND_SET, 100, 50);
		send_request(MODE_FIND_SET, 33, TOTAL_LIM);
		send_request(MODE_FIND_SET, 32, 32);
		send_request(MODE_FIND_ZERO, 0, TOTAL_LIM);
		send_request(MODE_FIND_ZERO, 31, 33);
		send_request(MODE_FIND_SET, IDX_W'(TOTAL_BITS - 1), TOTAL_LIM);
		send_request(MODE_TEST_SET, IDX_W'(TOTAL_BITS - 1), 0);
		send_request(MODE_FIND_SET, IDX_W'(TOTAL_BITS - 1), TOTAL_LIM);
		send_request(MODE_FIND_SET, 1000, LIM_W'(TOTAL_BITS - 1));
		// unused codes must leave the bitmap alone and return zeros
		for (m = MODE_W'(MODE_FIND_ZERO + 1); m != 0; m++)
			send_request(m, IDX_W'(TOTAL_BITS - 1), LIM_W'(2 ** LIM_W - 1));
		send_request(MODE_TEST, 0, 0);
	endtask

	task automatic test_random_traffic(input int n);
		int k;
		int hot;
		hot = 0;
		for (k = 0; k < n; k++) begin
			if (k % 64 == 0)
				hot = $urandom_range(0, WORDS - 3);
			// drop all idling for a stretch now and then
			gaps_on   = (k % 160) >= 40;
			stalls_on = (k % 160) >= 40;
			send_random(hot);
		end
	endtask

	// Fill five neighbouring words so that zero searches have to walk over them.
	task automatic test_dense_region();
		int first;
		int k;
		int start;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		first = $urandom_range(0, WORDS - 6) * WORD_BITS;
		for (k = 0; k < 5 * WORD_BITS; k++) begin
			send_request(MODE_TEST_SET, IDX_W'(first + k), TOTAL_LIM);
			if (k % 16 == 15)
				send_request(MODE_FIND_ZERO, IDX_W'(first + $urandom_range(0, k)),
					LIM_W'($urandom_range(0, TOTAL_BITS)));
		end
		for (k = 0; k < 20; k++) begin
			start = first + $urandom_range(0, 5 * WORD_BITS - 1);
			send_request(k % 4 == 0 ? MODE_FIND_SET : MODE_FIND_ZERO, IDX_W'(start),
				LIM_W'(start + $urandom_range(0, 7 * WORD_BITS)));
		end
		for (k = 0; k < 6; k++)
			send_request(MODE_TEST_CLEAR, IDX_W'(first + $urandom_range(0, 5 * WORD_BITS - 1)),
				TOTAL_LIM);
		for (k = 0; k < 4; k++)
			send_request(MODE_FIND_ZERO, IDX_W'(first + $urandom_range(0, WORD_BITS - 1)),
				TOTAL_LIM);
	endtask

	// Hold the receiver off while requests keep coming, so the engine backs up.
	task automatic test_backpressure();
		int k;
		int hot;
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		holdoff_cycles = 400;
		hot = $urandom_range(0, WORDS - 3);
		for (k = 0; k < 40; k++)
			send_random(hot);
	endtask

	initial begin : receiver
		int run;
		run = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (holdoff_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				holdoff_cycles--;
			end else if (run > 0) begin
				run--;
			end else if (rsp_ch.ready && stalls_on) begin
				rsp_ch.ready <= 1'b0;
				run = $urandom_range(0, 5);
			end else begin
				rsp_ch.ready <= 1'b1;
				run = $urandom_range(0, 15);
			end
		end
	end

	always @(posedge clk) begin : result_check
		bit_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual old_bit=%0d found_index=%0d",
					$time, rsp_ch.old_bit, rsp_ch.found_index);
				err_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.old_bit !== want.old_bit) begin
					$display("%0t: old_bit mismatch, expected %0d, actual %0d",
						$time, want.old_bit, rsp_ch.old_bit);
					err_count++;
				end
				if (rsp_ch.found_index !== want.found_index) begin
					$display("%0t: found_index mismatch, expected %0d, actual %0d",
						$time, want.found_index, rsp_ch.found_index);
					err_count++;
				end
			end
		end
	end

	initial begin : main
		int waited;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.mode         = MODE_TEST;
		req_ch.bit_index    = '0;
		req_ch.search_limit = '0;
		foreach (shadow_map[i])
			shadow_map[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_bit_updates();
		test_search_edges();
		test_random_traffic(500);
		test_dense_region();
		test_backpressure();

		@(negedge clk);
		req_ch.valid <= 1'b0;
		stalls_on = 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 50000) begin
			@(posedge clk);
			waited++;
		end
		repeat (2 * WORDS) @(posedge clk);
		if (pending_results.size() != 0) begin
			$display("%0t: %0d results never arrived, expected %0d, actual 0",
				$time, pending_results.size(), pending_results.size());
			err_count++;
		end
		if (err_count == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
